// ===== src/ptq_pkg.sv =====
package ptq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int PRIO_W   = 8;
  localparam int HANDLE_W = 16;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
  localparam logic [ID_W-1:0] ID_LAST  = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

endpackage

// ===== src/ptq_in_if.sv =====
interface ptq_in_if import ptq_pkg::*;;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [PRIO_W-1:0]   prio;
  logic [HANDLE_W-1:0] task_handle;

  modport source (output valid, output cmd, output prio, output task_handle, input ready);
  modport sink (input valid, input cmd, input prio, input task_handle, output ready);
endinterface

// ===== src/ptq_out_if.sv =====
interface ptq_out_if import ptq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     task_id;
  logic [PRIO_W-1:0]   out_prio;
  logic [HANDLE_W-1:0] out_handle;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output task_id, output out_prio,
                  output out_handle, output occupancy, input ready);
  modport sink (input valid, input status, input task_id, input out_prio,
                input out_handle, input occupancy, output ready);
endinterface

// ===== src/priority_task_queue_top.sv =====
// push: accepted in S_IDLE, then the slot is written and the result registered in S_COMMIT
// pop: one slot read per cycle over DEPTH slots in S_SCAN, then the result is registered in S_COMMIT
// one transaction in flight; the single slot read port and compare unit set the pop time
// a new transaction is accepted while a result waits; commit stalls until that result is taken
// synchronous active-low reset: queue empty, next id 1, no result pending
module priority_task_queue_top import ptq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  ptq_in_if.sink   in_ch,
  ptq_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic [DEPTH-1:0]    slot_valid_r, slot_valid_nxt;
  logic [CNT_W-1:0]    fill_count_r, fill_count_nxt;
  logic [ID_W-1:0]     id_ctr_r, id_ctr_nxt;
  logic [CNT_W-1:0]    scan_cnt_r;

  logic                op_cmd_r;
  logic [PRIO_W-1:0]   op_prio_r;
  logic [HANDLE_W-1:0] op_handle_r;

  logic [PRIO_W-1:0]   prio_mem   [DEPTH];
  logic [ID_W-1:0]     id_mem     [DEPTH];
  logic [HANDLE_W-1:0] handle_mem [DEPTH];

  logic                rd_hit_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [PRIO_W-1:0]   rd_prio_r;
  logic [ID_W-1:0]     rd_id_r;
  logic [HANDLE_W-1:0] rd_handle_r;

  logic                best_found_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [PRIO_W-1:0]   best_prio_r;
  logic [ID_W-1:0]     best_id_r;
  logic [HANDLE_W-1:0] best_handle_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [PRIO_W-1:0]   out_prio_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic             in_ready;
  logic             accept;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             commit_en;
  logic             take;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             mem_we;

  assign accept  = in_ch.valid && in_ready;
  assign rd_addr = scan_cnt_r[IDX_W-1:0];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // shared compare unit
  assign take = rd_hit_r && (!best_found_r || (rd_prio_r > best_prio_r) ||
                ((rd_prio_r == best_prio_r) && (rd_id_r < best_id_r)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.cmd == CMD_PUSH) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt_r == CNT_W'(DEPTH)) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_en) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    commit_en = 1'b0;
    case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_SCAN:   rd_en = (scan_cnt_r < CNT_W'(DEPTH));
      S_COMMIT: commit_en = !out_valid_r || out_ch.ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign mem_we = commit_en && (op_cmd_r == CMD_PUSH) && free_found;

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    fill_count_nxt = fill_count_r;
    id_ctr_nxt     = id_ctr_r;
    if (mem_we) begin
      slot_valid_nxt[free_idx] = 1'b1;
      fill_count_nxt = fill_count_r + CNT_W'(1);
      id_ctr_nxt     = (id_ctr_r == ID_LAST) ? ID_FIRST : id_ctr_r + ID_W'(1);
    end else if (commit_en && (op_cmd_r == CMD_POP) && best_found_r) begin
      slot_valid_nxt[best_idx_r] = 1'b0;
      fill_count_nxt = fill_count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      fill_count_r <= '0;
      id_ctr_r     <= ID_FIRST;
      scan_cnt_r   <= '0;
      rd_hit_r     <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      fill_count_r <= fill_count_nxt;
      id_ctr_r     <= id_ctr_nxt;
      rd_hit_r     <= rd_en && slot_valid_r[rd_addr];
      if (accept) begin
        scan_cnt_r   <= '0;
        best_found_r <= 1'b0;
      end else begin
        if (rd_en) begin
          scan_cnt_r <= scan_cnt_r + CNT_W'(1);
        end
        if (take) begin
          best_found_r <= 1'b1;
        end
      end
      if (commit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      prio_mem[free_idx]   <= op_prio_r;
      id_mem[free_idx]     <= id_ctr_r;
      handle_mem[free_idx] <= op_handle_r;
    end
    if (rd_en) begin
      rd_idx_r    <= rd_addr;
      rd_prio_r   <= prio_mem[rd_addr];
      rd_id_r     <= id_mem[rd_addr];
      rd_handle_r <= handle_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd_r    <= in_ch.cmd;
      op_prio_r   <= in_ch.prio;
      op_handle_r <= in_ch.task_handle;
    end
    if (take) begin
      best_idx_r    <= rd_idx_r;
      best_prio_r   <= rd_prio_r;
      best_id_r     <= rd_id_r;
      best_handle_r <= rd_handle_r;
    end
    if (commit_en) begin
      out_occ_r <= OCC_W'(fill_count_nxt);
      if (op_cmd_r == CMD_PUSH) begin
        out_status_r <= free_found ? ST_OK : ST_FULL;
        out_id_r     <= free_found ? id_ctr_r : '0;
        out_prio_r   <= '0;
        out_handle_r <= '0;
      end else if (best_found_r) begin
        out_status_r <= ST_OK;
        out_id_r     <= best_id_r;
        out_prio_r   <= best_prio_r;
        out_handle_r <= best_handle_r;
      end else begin
        out_status_r <= ST_EMPTY;
        out_id_r     <= '0;
        out_prio_r   <= '0;
        out_handle_r <= '0;
      end
    end
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.task_id    = out_id_r;
  assign out_ch.out_prio   = out_prio_r;
  assign out_ch.out_handle = out_handle_r;
  assign out_ch.occupancy  = out_occ_r;

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r == CNT_W'($countones(slot_valid_r)))
    else $error("fill count out of step with slot valid bits");

  a_id_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
    id_ctr_r != '0)
    else $error("id counter reached zero");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (fill_count_r == CNT_W'(DEPTH)))
    else $error("full status with free slots");

  a_occ_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_occ_r == OCC_W'(fill_count_r)))
    else $error("reported occupancy differs from fill count");

  a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |=> !rd_hit_r)
    else $error("slot read outside pop scan");

endmodule
